FILE: hdl/pmm_pkg.sv
package pmm_pkg;

   localparam int DEF_MAX_CHANNELS  = 64;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int SAMPLE_W = 64;
   localparam int MONO_W   = 16;
   localparam int CFG_W    = 7;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_ENCODING = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BITS     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT    = 2'd2;

   localparam logic ENC_INT   = 1'b0;
   localparam logic ENC_FLOAT = 1'b1;

   localparam logic [CFG_W-1:0] BITS_8  = 7'd8;
   localparam logic [CFG_W-1:0] BITS_16 = 7'd16;
   localparam logic [CFG_W-1:0] BITS_24 = 7'd24;
   localparam logic [CFG_W-1:0] BITS_32 = 7'd32;
   localparam logic [CFG_W-1:0] BITS_64 = 7'd64;

   localparam logic             RST_ENCODING = ENC_INT;
   localparam logic [CFG_W-1:0] RST_BITS     = BITS_16;
   localparam logic [CFG_W-1:0] RST_COUNT    = 7'd1;

   // The full scale 32767 is 2^15 - 1, so a product by it is a shift and a subtract.
   localparam int          FS_SHIFT   = 15;
   localparam logic [14:0] FULL_SCALE = 15'h7FFF;

   localparam int MANT_W = 53;
   localparam int P_W    = MANT_W + FS_SHIFT;

   localparam logic [7:0]  F32_EXP_ONES = 8'hFF;
   localparam logic [7:0]  F32_BIAS     = 8'd127;
   localparam logic [10:0] F64_EXP_ONES = 11'h7FF;
   localparam logic [10:0] F64_BIAS     = 11'd1023;

   // Bias plus mantissa bits of each format; the rounding shift is this minus
   // the fraction bits minus the exponent.
   localparam int F32_SH_OFFSET = 127 + 23;
   localparam int F64_SH_OFFSET = 1023 + 52;

   localparam int          SH_FULL_W = 11;
   localparam int          SH_W      = 7;
   localparam logic [SH_W-1:0] SH_CLAMP = 7'd70;

   localparam int MONO_MAX     = 32767;
   localparam int MONO_MIN_MAG = 32768;

   typedef struct packed {
      logic load_in;
      logic accumulate;
      logic load_div;
      logic div_step;
      logic load_out;
      logic clear_frame;
   } pmm_cmd_type;

endpackage

FILE: hdl/pmm_req_if.sv
interface pmm_req_if import pmm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_word;

   modport source (output valid, output sample_word, input ready);
   modport sink (input valid, input sample_word, output ready);
endinterface

FILE: hdl/pmm_rsp_if.sv
interface pmm_rsp_if import pmm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [MONO_W-1:0] mono_sample;
   logic                     status;

   modport source (output valid, output mono_sample, output status, input ready);
   modport sink (input valid, input mono_sample, input status, output ready);
endinterface

FILE: hdl/pmm_divider.sv
module pmm_divider import pmm_pkg::*; #(
   parameter int Q_W   = 23,
   parameter int CNT_W = 7
) (
   input  logic             clock,
   input  logic             start,
   input  logic             step,
   input  logic [Q_W-1:0]   dividend,
   input  logic [CNT_W-1:0] divisor,
   output logic [Q_W-1:0]   quotient
);

   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]   quo_ff, quo_in;
   logic [CNT_W:0]   trial;
   logic             qbit;

   always_comb begin
      trial = {rem_ff, quo_ff[Q_W-1]};
      qbit  = (trial >= {1'b0, divisor});
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (start) begin
         rem_in = '0;
         quo_in = dividend;
      end else if (step) begin
         rem_in = qbit ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
         quo_in = {quo_ff[Q_W-2:0], qbit};
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign quotient = quo_ff;

endmodule

FILE: hdl/pmm_datapath.sv
module pmm_datapath import pmm_pkg::*; #(
   parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  pmm_cmd_type                             cmd,
   input  logic                                    sample_encoding,
   input  logic [CFG_W-1:0]                        sample_bits,
   input  logic [$clog2(MAX_CHANNELS+1)-1:0]       chans,
   input  logic [SAMPLE_W-1:0]                     sample_word,
   output logic signed [MONO_W-1:0]                mono_sample,
   output logic                                    status
);

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int SUM_W = 16 + FRACTION_BITS + $clog2(MAX_CHANNELS);
   localparam int MAG_W = 16 + FRACTION_BITS;
   localparam int Q_W   = 17 + $clog2(MAX_CHANNELS);
   localparam int X_W   = SUM_W + 2;
   localparam logic [SH_FULL_W-1:0] F32_SH_BASE = SH_FULL_W'(F32_SH_OFFSET - FRACTION_BITS);
   localparam logic [SH_FULL_W-1:0] F64_SH_BASE = SH_FULL_W'(F64_SH_OFFSET - FRACTION_BITS);
   localparam logic [P_W-1:0]       FULL_P = P_W'(FULL_SCALE) << FRACTION_BITS;

   logic [MONO_W-1:0]    int_val;
   logic [MONO_W-1:0]    int_mag;
   logic [7:0]           ex32;
   logic [10:0]          ex64;
   logic [MANT_W-1:0]    mant;
   logic [SH_FULL_W-1:0] sh_full;
   logic                 use_mult;
   logic                 conv_neg;
   logic                 conv_bad;
   logic [P_W-1:0]       conv_p;
   logic [SH_W-1:0]      conv_sh;

   logic [P_W-1:0]  p_ff;
   logic [SH_W-1:0] sh_ff;
   logic            neg_ff;
   logic            bad_ff;

   logic [P_W-1:0] shifted;
   logic [P_W:0]   rnd;
   logic [P_W-1:0] rmag;
   logic [SUM_W-1:0] magx;
   logic [SUM_W-1:0] term;

   logic [SUM_W-1:0] frame_sum_ff, frame_sum_in;
   logic             frame_bad_ff, frame_bad_in;

   logic [SUM_W-1:0] sum_mag;
   logic [X_W-1:0]   xnum;
   logic [Q_W-1:0]   yval;
   logic [Q_W-1:0]   quotient;
   logic             fneg_ff;
   logic             fbad_ff;
   logic [MONO_W-1:0] avg;
   logic [MONO_W-1:0] mono_ff, mono_in;
   logic              status_ff, status_in;

   always_comb begin
      int_val  = '0;
      int_mag  = '0;
      ex32     = sample_word[30:23];
      ex64     = sample_word[62:52];
      mant     = '0;
      sh_full  = '0;
      use_mult = 1'b0;
      conv_neg = 1'b0;
      conv_bad = 1'b0;
      conv_p   = '0;
      if (sample_encoding == ENC_INT) begin
         unique case (sample_bits)
            BITS_8:  int_val = {~sample_word[7], sample_word[6:0], 8'h00};
            BITS_16: int_val = sample_word[15:0];
            BITS_24: int_val = sample_word[23:8];
            BITS_32: int_val = sample_word[31:16];
            default: conv_bad = 1'b1;
         endcase
         conv_neg = int_val[MONO_W-1];
         int_mag  = conv_neg ? (~int_val + 16'd1) : int_val;
         conv_p   = P_W'(int_mag) << FRACTION_BITS;
      end else begin
         unique case (sample_bits)
            BITS_32: begin
               conv_neg = sample_word[31];
               if (ex32 == F32_EXP_ONES) begin
                  conv_bad = 1'b1;
               end else if (ex32 >= F32_BIAS) begin
                  conv_p = FULL_P;
               end else begin
                  use_mult = 1'b1;
                  mant     = MANT_W'({ex32 != 8'd0, sample_word[22:0]});
                  sh_full  = F32_SH_BASE - SH_FULL_W'((ex32 == 8'd0) ? 8'd1 : ex32);
               end
            end
            BITS_64: begin
               conv_neg = sample_word[63];
               if (ex64 == F64_EXP_ONES) begin
                  conv_bad = 1'b1;
               end else if (ex64 >= F64_BIAS) begin
                  conv_p = FULL_P;
               end else begin
                  use_mult = 1'b1;
                  mant     = {ex64 != 11'd0, sample_word[51:0]};
                  sh_full  = F64_SH_BASE - ((ex64 == 11'd0) ? 11'd1 : ex64);
               end
            end
            default: conv_bad = 1'b1;
         endcase
         if (use_mult) begin
            conv_p = (P_W'(mant) << FS_SHIFT) - P_W'(mant);
         end
      end
      conv_sh = (sh_full > SH_FULL_W'(SH_CLAMP)) ? SH_CLAMP : sh_full[SH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         p_ff   <= conv_p;
         sh_ff  <= conv_sh;
         neg_ff <= conv_neg;
         bad_ff <= conv_bad;
      end
   end

   // Round half away from zero: shift by one less, add one, drop the last bit.
   always_comb begin
      shifted = p_ff >> (sh_ff - SH_W'(1));
      rnd     = (P_W + 1)'(shifted) + (P_W + 1)'(1);
      rmag    = (sh_ff == '0) ? p_ff : rnd[P_W:1];
      magx    = SUM_W'(rmag[MAG_W-1:0]);
      term    = neg_ff ? (~magx + SUM_W'(1)) : magx;
   end

   always_comb begin
      frame_sum_in = frame_sum_ff;
      frame_bad_in = frame_bad_ff;
      if (cmd.clear_frame) begin
         frame_sum_in = '0;
         frame_bad_in = 1'b0;
      end else if (cmd.accumulate) begin
         if (bad_ff) begin
            frame_bad_in = 1'b1;
         end else begin
            frame_sum_in = frame_sum_ff + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_sum_ff <= '0;
         frame_bad_ff <= 1'b0;
      end else begin
         frame_sum_ff <= frame_sum_in;
         frame_bad_ff <= frame_bad_in;
      end
   end

   // The average is floor((2|sum| + den) / (2 den)) with den = chans << FRACTION_BITS;
   // the power of two comes off first, leaving a division by the channel count.
   always_comb begin
      sum_mag = frame_sum_ff[SUM_W-1] ? (~frame_sum_ff + SUM_W'(1)) : frame_sum_ff;
      xnum    = (X_W'(sum_mag) << 1) + (X_W'(chans) << FRACTION_BITS);
      yval    = Q_W'(xnum >> (FRACTION_BITS + 1));
   end

   always_ff @(posedge clock) begin
      if (cmd.load_div) begin
         fneg_ff <= frame_sum_ff[SUM_W-1];
         fbad_ff <= frame_bad_ff;
      end
   end

   pmm_divider #(
      .Q_W   (Q_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .start    (cmd.load_div),
      .step     (cmd.div_step),
      .dividend (yval),
      .divisor  (chans),
      .quotient (quotient)
   );

   always_comb begin
      avg       = '0;
      mono_in   = mono_ff;
      status_in = status_ff;
      if (cmd.load_out) begin
         if (fbad_ff) begin
            mono_in   = '0;
            status_in = 1'b1;
         end else if (fneg_ff) begin
            avg       = (quotient > Q_W'(MONO_MIN_MAG)) ? MONO_W'(MONO_MIN_MAG)
                                                        : quotient[MONO_W-1:0];
            mono_in   = ~avg + MONO_W'(1);
            status_in = 1'b0;
         end else begin
            mono_in   = (quotient > Q_W'(MONO_MAX)) ? MONO_W'(MONO_MAX)
                                                    : quotient[MONO_W-1:0];
            status_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mono_ff   <= mono_in;
      status_ff <= status_in;
   end

   assign mono_sample = mono_ff;
   assign status      = status_ff;

endmodule

FILE: hdl/pmm_ctrl.sv
module pmm_ctrl import pmm_pkg::*; #(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cfg_clear,
   input  logic [$clog2(MAX_CHANNELS+1)-1:0] chans,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output pmm_cmd_type                       cmd
);

   localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
   localparam int Q_W    = 17 + $clog2(MAX_CHANNELS);
   localparam int ITER_W = $clog2(Q_W + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ACC  = 3'd1;
   localparam logic [2:0] S_LOAD = 3'd2;
   localparam logic [2:0] S_DIV  = 3'd3;
   localparam logic [2:0] S_OUT  = 3'd4;

   logic [2:0]        state_ff, state_in;
   logic [CNT_W-1:0]  index_ff, index_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]  index_next;

   always_comb begin
      state_in     = state_ff;
      index_in     = index_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      index_next   = index_ff + CNT_W'(1);
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in    = S_ACC;
            end
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            if (index_next == chans) begin
               index_in = '0;
               state_in = S_LOAD;
            end else begin
               index_in = index_next;
               state_in = S_IDLE;
            end
         end
         S_LOAD: begin
            cmd.load_div    = 1'b1;
            cmd.clear_frame = 1'b1;
            iter_in         = ITER_W'(Q_W);
            state_in        = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            iter_in      = iter_ff - ITER_W'(1);
            if (iter_ff == ITER_W'(1)) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (cfg_clear) begin
         cmd.clear_frame = 1'b1;
         index_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         index_ff     <= '0;
         iter_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         index_ff     <= index_in;
         iter_ff      <= iter_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: hdl/pcm_multichannel_to_mono16.sv
// Each item is accepted and converted in the idle state, then accumulated in ACC;
// no new item is taken before the last one is accumulated. The last item of a
// frame then passes a load state, one divider step per quotient bit of the
// shift-subtract divider, and the output register load, which waits while a
// response is still pending. Synchronous active-high reset clears the registers to
// integer, 16 bits, one channel, empties the frame accumulator and clears the
// response valid; the output register itself is not reset.
module pcm_multichannel_to_mono16 import pmm_pkg::*; #(
   parameter int MAX_CHANNELS  = DEF_MAX_CHANNELS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   pmm_req_if.sink              req_ch,
   pmm_rsp_if.source            rsp_ch
);

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);

   logic             encoding_ff, encoding_in;
   logic [CFG_W-1:0] bits_ff, bits_in;
   logic [CFG_W-1:0] count_ff, count_in;
   logic             cfg_clear;
   logic [CNT_W-1:0] chans;
   logic             req_ready;
   logic             rsp_valid;
   pmm_cmd_type      cmd;
   logic [MONO_W-1:0] mono_sample;
   logic             status;

   always_comb begin
      encoding_in = encoding_ff;
      bits_in     = bits_ff;
      count_in    = count_ff;
      cfg_clear   = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ENCODING: begin
               encoding_in = csr_wdata[0];
               cfg_clear   = 1'b1;
            end
            CSR_BITS: begin
               bits_in   = csr_wdata;
               cfg_clear = 1'b1;
            end
            CSR_COUNT: begin
               count_in  = csr_wdata;
               cfg_clear = 1'b1;
            end
            default: cfg_clear = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff <= RST_ENCODING;
         bits_ff     <= RST_BITS;
         count_ff    <= RST_COUNT;
      end else begin
         encoding_ff <= encoding_in;
         bits_ff     <= bits_in;
         count_ff    <= count_in;
      end
   end

   // A count of zero acts as one, and a count above the maximum as the maximum.
   always_comb begin
      if (count_ff == '0) begin
         chans = CNT_W'(1);
      end else if (count_ff > CFG_W'(MAX_CHANNELS)) begin
         chans = CNT_W'(MAX_CHANNELS);
      end else begin
         chans = CNT_W'(count_ff);
      end
   end

   pmm_ctrl #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg_clear (cfg_clear),
      .chans     (chans),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   pmm_datapath #(
      .MAX_CHANNELS  (MAX_CHANNELS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sample_encoding (encoding_ff),
      .sample_bits     (bits_ff),
      .chans           (chans),
      .sample_word     (req_ch.sample_word),
      .mono_sample     (mono_sample),
      .status          (status)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.mono_sample = mono_sample;
   assign rsp_ch.status      = status;

endmodule
